/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define SHA1_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequence holds in the cycle after the trigger
`define SHA1_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) trig |=> cons) else $error(msg);

`endif

/* rtl/sha1_pkg.sv */
package sha1_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] hash_t;

	localparam int unsigned CNT_W = 61;
	localparam logic [2:0] LAST_IDX = 3'd4;
	localparam logic [3:0] LAST_BLK_WORD = 4'd15;
	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;
	localparam logic [5:0] LAST_SLOT = 6'd63;
	localparam logic [5:0] LEN_SLOT = 6'd56;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam hash_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	typedef struct packed {
		logic start;
		logic hash_init;
	} core_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	// big-endian byte lane insert
	function automatic word_t place_byte(word_t w, logic [7:0] b, logic [1:0] lane);
		word_t r;
		r = w;
		unique case (lane)
			2'd0: r[31:24] = w[31:24] | b;
			2'd1: r[23:16] = w[23:16] | b;
			2'd2: r[15:8] = w[15:8] | b;
			2'd3: r[7:0] = w[7:0] | b;
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

/* rtl/sha1_block_mem.sv */
module sha1_block_mem (
	input logic clk,
	input logic we,
	input logic [3:0] waddr,
	input sha1_pkg::word_t wdata,
	input logic [3:0] raddr,
	output sha1_pkg::word_t rdata
);

	sha1_pkg::word_t mem [16];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/sha1_core.sv */
module sha1_core (
	input logic clk,
	input logic arst_n,
	input sha1_pkg::core_ctrl_t ctrl,
	output sha1_pkg::core_stat_t stat,
	output logic [3:0] rd_addr,
	input sha1_pkg::word_t rd_data,
	output sha1_pkg::hash_t hash
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RND = 3'b010,
		C_UPD = 3'b100
	} core_state_t;

	core_state_t state_q;
	logic [6:0] r_q;
	sha1_pkg::hash_t h_q;
	sha1_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	sha1_pkg::word_t w_q [16];
	sha1_pkg::word_t w_new, f, k, t;

	function automatic sha1_pkg::word_t rotl1(sha1_pkg::word_t x);
		return {x[30:0], x[31]};
	endfunction

	function automatic sha1_pkg::word_t rotl5(sha1_pkg::word_t x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic sha1_pkg::word_t rotl30(sha1_pkg::word_t x);
		return {x[1:0], x[31:2]};
	endfunction

	assign stat = '{busy: (state_q != C_IDLE), done: (state_q == C_UPD)};
	assign hash = h_q;
	assign rd_addr = (state_q == C_RND) ? (r_q[3:0] + 4'd1) : 4'd0;

	// first 16 rounds take the block from memory, the rest from the window
	assign w_new = (r_q < 7'd16) ? rd_data : rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);

	always_comb begin
		priority if (r_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1_pkg::K0;
		end else if (r_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K1;
		end else if (r_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K3;
		end
	end

	assign t = rotl5(a_q) + f + e_q + w_new + k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			r_q <= '0;
			h_q <= sha1_pkg::H_INIT;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (ctrl.hash_init) begin
						h_q <= sha1_pkg::H_INIT;
					end
					if (ctrl.start) begin
						r_q <= '0;
						state_q <= C_RND;
					end
				end
				C_RND: begin
					r_q <= r_q + 7'd1;
					if (r_q == sha1_pkg::LAST_ROUND) begin
						state_q <= C_UPD;
					end
				end
				C_UPD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctrl.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == C_RND) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= rotl30(b_q);
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
	end

endmodule

/* rtl/sha1_digest_out.sv */
module sha1_digest_out (
	input logic clk,
	input logic arst_n,
	input logic load,
	input sha1_pkg::hash_t hash,
	input logic flag,
	output logic free,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word,
	output logic length_overflow
);

	logic valid_q;
	logic [2:0] idx_q;
	logic flag_q;
	sha1_pkg::hash_t words_q;
	logic take;

	assign take = valid_q && !out_stall;
	assign free = !valid_q;
	assign out_valid = valid_q;
	assign digest_word = words_q[0];
	assign word_index = idx_q;
	assign last_word = (idx_q == sha1_pkg::LAST_IDX);
	assign length_overflow = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (idx_q == sha1_pkg::LAST_IDX) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	// digest shifts down one word per item taken
	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= hash;
			flag_q <= flag;
		end else if (take) begin
			words_q <= {32'd0, words_q[4:1]};
		end
	end

endmodule

/* rtl/sha1_hash_engine.sv */
// SHA-1 engine over a byte stream. Each input item is either a message byte (op 0) or a
// finish command (op 1). Bytes are packed big-endian into a 16-word block memory; byte
// items are taken back to back, and the 64th byte of a block starts the compression, which
// holds in_stall high through 80 rounds at one round per cycle and the final hash add. A
// finish item writes the padding words into the block memory (one word per cycle, from the
// current word through word 15), compresses once, or twice when the length does not fit
// behind the 0x80 marker, then hands the digest to an output buffer and returns to the
// initial hash; the finish waits while the output buffer still holds the previous digest.
// The five digest words leave word 0 first, with last_word on word 4, and the buffer
// drains while new message bytes are already taken. A message longer than 2^64-1 bits
// sets an overflow flag, sticky until finish, that reaches length_overflow with the digest;
// bytes past that point are dropped and the digest covers the length that was kept.
`include "assert_macros.svh"

module sha1_hash_engine (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic op,
	input logic [7:0] data_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word,
	output logic length_overflow
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD = 4'b0010,
		ST_HASH = 4'b0100,
		ST_FIN = 4'b1000
	} eng_state_t;

	eng_state_t state_q;
	logic [5:0] pos_q;
	sha1_pkg::word_t acc_q;
	logic [sha1_pkg::CNT_W-1:0] cnt_q;
	logic ovf_q;
	logic fin_q;
	logic two_q;
	logic mark_q;
	logic [3:0] widx_q;

	logic in_acc;
	logic byte_take;
	sha1_pkg::word_t acc_new;
	sha1_pkg::word_t acc_marked;
	sha1_pkg::word_t pad_word;
	logic [63:0] bit_len;

	logic mem_we;
	logic [3:0] mem_waddr;
	sha1_pkg::word_t mem_wdata;
	logic [3:0] mem_raddr;
	sha1_pkg::word_t mem_rdata;

	sha1_pkg::core_ctrl_t core_ctrl;
	sha1_pkg::core_stat_t core_stat;
	sha1_pkg::hash_t core_hash;

	logic out_free;
	logic out_load;

	// only the idle state takes items
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	// a byte is dropped once the length would pass 2^64-1 bits
	assign byte_take = in_acc && !op && !ovf_q && !(&cnt_q);

	assign acc_new = sha1_pkg::place_byte(acc_q, data_byte, pos_q[1:0]);
	assign acc_marked = sha1_pkg::place_byte(acc_q, sha1_pkg::PAD_MARK, pos_q[1:0]);
	assign bit_len = {cnt_q, 3'b000};

	// padding words: marker word first, zeros, length in the last block only
	always_comb begin
		priority if (mark_q) begin
			pad_word = acc_marked;
		end else if (!two_q && widx_q == sha1_pkg::LEN_HI_WORD) begin
			pad_word = bit_len[63:32];
		end else if (!two_q && widx_q == sha1_pkg::LEN_LO_WORD) begin
			pad_word = bit_len[31:0];
		end else begin
			pad_word = '0;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_q[5:2];
		mem_wdata = acc_new;
		core_ctrl.start = 1'b0;
		core_ctrl.hash_init = out_load;
		unique case (state_q)
			ST_IDLE: begin
				// a word goes to memory when its fourth byte arrives
				mem_we = byte_take && (pos_q[1:0] == 2'd3);
				core_ctrl.start = byte_take && (pos_q == sha1_pkg::LAST_SLOT);
			end
			ST_PAD: begin
				mem_we = 1'b1;
				mem_waddr = widx_q;
				mem_wdata = pad_word;
				core_ctrl.start = (widx_q == sha1_pkg::LAST_BLK_WORD);
			end
			ST_HASH, ST_FIN: begin
				mem_we = 1'b0;
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign out_load = (state_q == ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			fin_q <= 1'b0;
			two_q <= 1'b0;
			mark_q <= 1'b0;
			widx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && op) begin
						// finish: pad from the current word on
						widx_q <= pos_q[5:2];
						mark_q <= 1'b1;
						fin_q <= 1'b1;
						two_q <= (pos_q >= sha1_pkg::LEN_SLOT);
						state_q <= ST_PAD;
					end else if (in_acc && !byte_take) begin
						ovf_q <= 1'b1;
					end else if (byte_take) begin
						cnt_q <= cnt_q + {{(sha1_pkg::CNT_W-1){1'b0}}, 1'b1};
						pos_q <= pos_q + 6'd1;
						acc_q <= (pos_q[1:0] == 2'd3) ? '0 : acc_new;
						if (pos_q == sha1_pkg::LAST_SLOT) begin
							fin_q <= 1'b0;
							state_q <= ST_HASH;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b0;
					widx_q <= widx_q + 4'd1;
					if (widx_q == sha1_pkg::LAST_BLK_WORD) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (core_stat.done) begin
						if (!fin_q) begin
							state_q <= ST_IDLE;
						end else if (two_q) begin
							// length block follows the marker block
							two_q <= 1'b0;
							widx_q <= '0;
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						pos_q <= '0;
						acc_q <= '0;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						fin_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	sha1_block_mem u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sha1_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(core_ctrl),
		.stat(core_stat),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata),
		.hash(core_hash)
	);

	sha1_digest_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(out_load),
		.hash(core_hash),
		.flag(ovf_q),
		.free(out_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word),
		.length_overflow(length_overflow)
	);

	`SHA1_ASSERT(a_no_write_in_rounds, mem_we |-> !core_stat.busy, "block memory written during rounds")
	`SHA1_ASSERT(a_start_when_idle, core_ctrl.start |-> !core_stat.busy, "core started while busy")
	`SHA1_ASSERT(a_done_in_hash, core_stat.done |-> state_q == ST_HASH, "core done outside hash wait")
	`SHA1_ASSERT_NEXT(a_load_shows, out_load, out_valid && word_index == 3'd0, "digest not shown after load")

endmodule
